// ===== design/mfrf_pkg.sv =====
// Shared types, constants and the loop table for the mesh flood relay filter.
`default_nettype none

package mfrf_pkg;

  // Item kinds on the input side
  typedef enum logic [0:0] {
    OP_HEADER = 1'b0,
    OP_ENTRY  = 1'b1
  } op_e;

  // Verdict reason codes
  typedef enum logic [2:0] {
    REASON_ALLOW    = 3'd0,
    REASON_HOP      = 3'd1,
    REASON_UNSCOPED = 3'd2,
    REASON_ADVERT   = 3'd3,
    REASON_LOOP     = 3'd4
  } reason_e;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_FLOOD_LIMIT    = 3'd0,
    CFG_UNSCOPED_LIMIT = 3'd1,
    CFG_ADVERT_LIMIT   = 3'd2,
    CFG_LOOP_MODE      = 3'd3,
    CFG_SELF_PREFIX    = 3'd4
  } cfg_idx_e;

  // Loop detection modes
  typedef enum logic [1:0] {
    LOOP_OFF    = 2'd0,
    LOOP_LIGHT  = 2'd1,
    LOOP_NORMAL = 2'd2,
    LOOP_TIGHT  = 2'd3
  } loop_mode_e;

  localparam logic [5:0] MaxHops        = 6'd63;
  localparam logic [3:0] AdvertType     = 4'd4;
  localparam logic [1:0] FloodRouteCode = 2'd1;
  localparam logic [5:0] MatchMax       = 6'd63;
  localparam int unsigned QueueDepth    = 2;

  // Configuration registers as seen by the datapath
  typedef struct packed {
    logic [6:0]  flood_limit;
    logic [6:0]  unscoped_limit;
    logic [6:0]  advert_limit;
    loop_mode_e  loop_mode;
    logic [23:0] self_prefix;
  } cfg_t;

  // Classified item passed from the front to the back
  typedef struct packed {
    logic       start;    // header: restart the match count
    logic       emit;     // last item of the packet: give a verdict
    logic       match;    // entry equals own prefix and the loop check is on
    logic       loop_on;  // loop check made for this packet
    reason_e    reason;   // limit verdict taken at the header
    logic [2:0] loop_max; // table maximum for this packet
  } mid_item_t;

  // One verdict
  typedef struct packed {
    logic       allow;
    reason_e    reason;
    logic [5:0] hit_count;
  } result_t;

  // Table maximum for a loop mode and hash size; mode off selects the normal table
  function automatic logic [2:0] loop_max(loop_mode_e mode, logic [1:0] hsize);
    logic [2:0] val;
    case (mode)
      LOOP_LIGHT: begin
        case (hsize)
          2'd1:    val = 3'd4;
          2'd2:    val = 3'd2;
          2'd3:    val = 3'd1;
          default: val = 3'd0;
        endcase
      end
      LOOP_TIGHT: begin
        case (hsize)
          2'd1:    val = 3'd1;
          2'd2:    val = 3'd1;
          2'd3:    val = 3'd1;
          default: val = 3'd0;
        endcase
      end
      default: begin
        case (hsize)
          2'd1:    val = 3'd2;
          2'd2:    val = 3'd1;
          2'd3:    val = 3'd1;
          default: val = 3'd0;
        endcase
      end
    endcase
    return val;
  endfunction

  // Byte mask over the low hash-size bytes of a path hash
  function automatic logic [23:0] hash_mask(logic [1:0] hsize);
    logic [23:0] val;
    case (hsize)
      2'd1:    val = 24'h0000FF;
      2'd2:    val = 24'h00FFFF;
      2'd3:    val = 24'hFFFFFF;
      default: val = 24'h000000;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

// ===== design/mfrf_queue.sv =====
// Small first-in first-out queue used between the stages and at the output.
`default_nettype none

module mfrf_queue #(
  parameter int unsigned Width = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] data_i,
  output      logic             full_o,
  input  wire logic             pop_i,
  output      logic [Width-1:0] data_o,
  output      logic             empty_o
);

  localparam int unsigned Depth = mfrf_pkg::QueueDepth;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the item
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ===== design/mfrf_front.sv =====
// Front stage: accepts items, applies the hop limits and classifies path entries.
`default_nettype none

module mfrf_front (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire mfrf_pkg::cfg_t      cfg_i,
  input  wire logic                accept_i,
  input  wire logic                op_i,
  input  wire logic [1:0]          route_type_i,
  input  wire logic [3:0]          payload_type_i,
  input  wire logic [5:0]          hop_count_i,
  input  wire logic [2:0]          hash_size_i,
  input  wire logic [23:0]         path_entry_i,
  output      logic                mid_push_o,
  output      mfrf_pkg::mid_item_t mid_item_o
);

  logic [5:0]       entries_left_q, entries_left_d;
  logic [1:0]       hash_size_q, hash_size_d;
  logic             loop_on_q, loop_on_d;
  mfrf_pkg::reason_e reason_q, reason_d;

  logic [5:0]        hops;
  logic              flood;
  mfrf_pkg::reason_e hdr_reason;
  logic              hdr_loop_on;
  logic [23:0]       mask;
  logic              entry_eq;

  // Saturate the hop count and classify the header
  always_comb begin
    hops  = (hop_count_i > mfrf_pkg::MaxHops) ? mfrf_pkg::MaxHops : hop_count_i;
    flood = (route_type_i < 2'd2);
    hdr_reason = mfrf_pkg::REASON_ALLOW;
    if (flood) begin
      if ({1'b0, hops} >= cfg_i.flood_limit) begin
        hdr_reason = mfrf_pkg::REASON_HOP;
      end else if (route_type_i == mfrf_pkg::FloodRouteCode
                   && {1'b0, hops} >= cfg_i.unscoped_limit) begin
        hdr_reason = mfrf_pkg::REASON_UNSCOPED;
      end else if (payload_type_i == mfrf_pkg::AdvertType
                   && {1'b0, hops} >= cfg_i.advert_limit) begin
        hdr_reason = mfrf_pkg::REASON_ADVERT;
      end
    end
    hdr_loop_on = flood && (hdr_reason == mfrf_pkg::REASON_ALLOW)
                  && (cfg_i.loop_mode != mfrf_pkg::LOOP_OFF)
                  && (hash_size_i < 3'd4);
  end

  // Compare a path entry with the own prefix over the held hash size
  assign mask     = mfrf_pkg::hash_mask(hash_size_q);
  assign entry_eq = ((path_entry_i & mask) == (cfg_i.self_prefix & mask));

  // Track the packet and build the item for the back stage
  always_comb begin
    entries_left_d = entries_left_q;
    hash_size_d    = hash_size_q;
    loop_on_d      = loop_on_q;
    reason_d       = reason_q;
    mid_push_o     = 1'b0;
    mid_item_o     = '0;
    if (accept_i) begin
      if (op_i == mfrf_pkg::OP_HEADER) begin
        entries_left_d      = hops;
        hash_size_d         = hash_size_i[1:0];
        loop_on_d           = hdr_loop_on;
        reason_d            = hdr_reason;
        mid_push_o          = 1'b1;
        mid_item_o.start    = 1'b1;
        mid_item_o.emit     = (hops == '0);
        mid_item_o.match    = 1'b0;
        mid_item_o.loop_on  = hdr_loop_on;
        mid_item_o.reason   = hdr_reason;
        mid_item_o.loop_max = mfrf_pkg::loop_max(cfg_i.loop_mode, hash_size_i[1:0]);
      end else if (entries_left_q != '0) begin
        // Drop stray entries; count down the expected ones
        entries_left_d      = entries_left_q - 1'b1;
        mid_push_o          = 1'b1;
        mid_item_o.start    = 1'b0;
        mid_item_o.emit     = (entries_left_q == 6'd1);
        mid_item_o.match    = loop_on_q && entry_eq;
        mid_item_o.loop_on  = loop_on_q;
        mid_item_o.reason   = reason_q;
        mid_item_o.loop_max = mfrf_pkg::loop_max(cfg_i.loop_mode, hash_size_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entries_left_q <= '0;
      hash_size_q    <= 2'd1;
      loop_on_q      <= 1'b0;
      reason_q       <= mfrf_pkg::REASON_ALLOW;
    end else begin
      entries_left_q <= entries_left_d;
      hash_size_q    <= hash_size_d;
      loop_on_q      <= loop_on_d;
      reason_q       <= reason_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/mfrf_back.sv =====
// Back stage: counts own-prefix matches and forms the verdict of each packet.
`default_nettype none

module mfrf_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                mid_empty_i,
  input  wire mfrf_pkg::mid_item_t mid_item_i,
  output      logic                mid_pop_o,
  input  wire logic                res_full_i,
  output      logic                res_push_o,
  output      mfrf_pkg::result_t   res_o
);

  logic [5:0] count_q, count_d;
  logic [5:0] base;

  // Take an item when its verdict, if any, has room
  assign mid_pop_o  = !mid_empty_i && (!mid_item_i.emit || !res_full_i);
  assign res_push_o = mid_pop_o && mid_item_i.emit;

  // Update the match count, saturating
  always_comb begin
    base    = mid_item_i.start ? 6'd0 : count_q;
    count_d = base;
    if (mid_item_i.match && base < mfrf_pkg::MatchMax) begin
      count_d = base + 1'b1;
    end
  end

  // Form the verdict
  always_comb begin
    res_o.reason    = mid_item_i.reason;
    res_o.hit_count = mid_item_i.loop_on ? count_d : 6'd0;
    if (mid_item_i.reason == mfrf_pkg::REASON_ALLOW && mid_item_i.loop_on
        && count_d >= {3'd0, mid_item_i.loop_max}) begin
      res_o.reason = mfrf_pkg::REASON_LOOP;
    end
    res_o.allow = (res_o.reason == mfrf_pkg::REASON_ALLOW);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (mid_pop_o) begin
      count_q <= count_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/mesh_flood_relay_filter_top.sv =====
// Top level of the mesh flood relay filter: configuration, stages and queues.
// Throughput: one item per cycle, on the input and the result side alike, as long
// as the result queue does not fill up. A verdict passes the front stage into a
// two-entry queue and the back stage into a two-entry result queue, whose head
// drives the result ports. Reset empties both queues, clears the packet
// state and loads the registers with their reset values; no clearing pass.
`default_nettype none

module mesh_flood_relay_filter_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [23:0] cfg_data_i,
  input  wire logic        push,
  output      logic        full,
  input  wire logic        op_i,
  input  wire logic [1:0]  route_type_i,
  input  wire logic [3:0]  payload_type_i,
  input  wire logic [5:0]  hop_count_i,
  input  wire logic [2:0]  hash_size_i,
  input  wire logic [23:0] path_entry_i,
  output      logic        empty,
  input  wire logic        pop,
  output      logic        allow_o,
  output      logic [2:0]  reason_o,
  output      logic [5:0]  self_matches_o
);

  mfrf_pkg::cfg_t      cfg_q, cfg_d;
  logic                accept;
  logic                mid_push, mid_full, mid_pop, mid_empty;
  mfrf_pkg::mid_item_t mid_in, mid_out;
  logic                res_push, res_full;
  mfrf_pkg::result_t   res_in, res_out;

  // Write the configuration registers
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        mfrf_pkg::CFG_FLOOD_LIMIT:    cfg_d.flood_limit    = cfg_data_i[6:0];
        mfrf_pkg::CFG_UNSCOPED_LIMIT: cfg_d.unscoped_limit = cfg_data_i[6:0];
        mfrf_pkg::CFG_ADVERT_LIMIT:   cfg_d.advert_limit   = cfg_data_i[6:0];
        mfrf_pkg::CFG_LOOP_MODE:      cfg_d.loop_mode = mfrf_pkg::loop_mode_e'(cfg_data_i[1:0]);
        mfrf_pkg::CFG_SELF_PREFIX:    cfg_d.self_prefix    = cfg_data_i;
        default:                      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.flood_limit    <= 7'd64;
      cfg_q.unscoped_limit <= 7'd64;
      cfg_q.advert_limit   <= 7'd64;
      cfg_q.loop_mode      <= mfrf_pkg::LOOP_NORMAL;
      cfg_q.self_prefix    <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Accept an item while the middle queue has room
  assign full   = mid_full;
  assign accept = push && !mid_full;

  mfrf_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .accept_i       (accept),
    .op_i           (op_i),
    .route_type_i   (route_type_i),
    .payload_type_i (payload_type_i),
    .hop_count_i    (hop_count_i),
    .hash_size_i    (hash_size_i),
    .path_entry_i   (path_entry_i),
    .mid_push_o     (mid_push),
    .mid_item_o     (mid_in)
  );

  mfrf_queue #(
    .Width ($bits(mfrf_pkg::mid_item_t))
  ) u_mid_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .data_i  (mid_in),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .data_o  (mid_out),
    .empty_o (mid_empty)
  );

  mfrf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mid_empty_i (mid_empty),
    .mid_item_i  (mid_out),
    .mid_pop_o   (mid_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  mfrf_queue #(
    .Width ($bits(mfrf_pkg::result_t))
  ) u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_out),
    .empty_o (empty)
  );

  // Present the oldest verdict
  assign allow_o        = res_out.allow;
  assign reason_o       = res_out.reason;
  assign self_matches_o = res_out.hit_count;

endmodule

`default_nettype wire
